### hw/rtl/b32d_pkg.sv
package b32d_pkg;

   localparam logic [7:0] PAD_CHAR     = 8'h3D;
   localparam logic [7:0] UPPER_FIRST  = 8'h41;
   localparam logic [7:0] UPPER_LAST   = 8'h5A;
   localparam logic [7:0] LOWER_FIRST  = 8'h61;
   localparam logic [7:0] LOWER_LAST   = 8'h7A;
   localparam logic [7:0] DIGIT_FIRST  = 8'h32;
   localparam logic [7:0] DIGIT_LAST   = 8'h37;
   localparam logic [7:0] DIGIT_OFFSET = 8'd26;

   localparam int unsigned BUF_W   = 7;
   localparam int unsigned CNT_W   = 3;
   localparam int unsigned PADC_W  = 4;
   localparam logic [PADC_W-1:0] PAD_MAX = 4'd8;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_BAD_PAD  = 3'd1,
      STATUS_BAD_LEN  = 3'd2,
      STATUS_BAD_CHAR = 3'd3,
      STATUS_BAD_TAIL = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       has_char;
      logic       end_of_string;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       done_res;
      status_type status;
   } rsp_payload_type;

   typedef struct packed {
      logic       is_pad;
      logic       is_symbol;
      logic [4:0] symbol;
   } sym_info_type;

endpackage

### hw/rtl/base32_stream_decoder_unit.sv
// Streaming base32 decoder: one ASCII character per item, either letter case,
// padded or unpadded, with end_of_string on the final item. Decoded bytes
// appear as soon as eight bits have gathered, before the string's status is
// known, so discard them if the final result carries a nonzero status. The
// block takes one item per clock cycle while req_stall is low, and registers
// each result in a result register with a one-entry skid stage, which lets
// items keep flowing while a result waits; req_stall rises only while the
// skid entry is occupied.
module base32_stream_decoder_unit
   import b32d_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic [BUF_W-1:0]  buf_ff, buf_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [2:0]        dc_ff, dc_in;
   logic [PADC_W-1:0] padc_ff, padc_in;
   logic              seen_ff, seen_in;
   logic              pad_err_ff, pad_err_in;
   logic              char_err_ff, char_err_in;

   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type skid_ff, skid_in;

   sym_info_type    info;
   logic            accept;
   logic            out_take;
   logic            produce;
   rsp_payload_type result;

   logic [11:0]       combined;
   logic [11:0]       shifted;
   logic [CNT_W-1:0]  shift_n;
   logic [7:0]        mask;
   logic [4:0]        pad_sum;
   logic              byte_ok;
   logic [7:0]        byte_val;

   b32d_symbol_map u_symbol_map (
      .char_code (req_payload.char_code),
      .info      (info)
   );

   assign accept   = req_valid && !req_stall;
   assign out_take = out_valid_ff && !rsp_stall;

   always_comb begin
      buf_in      = buf_ff;
      cnt_in      = cnt_ff;
      dc_in       = dc_ff;
      padc_in     = padc_ff;
      seen_in     = seen_ff;
      pad_err_in  = pad_err_ff;
      char_err_in = char_err_ff;
      byte_ok     = 1'b0;
      byte_val    = 8'd0;
      combined    = {buf_ff, info.symbol};
      shift_n     = cnt_ff - 3'd3;
      shifted     = combined >> shift_n;
      mask        = (8'd1 << (cnt_ff + 3'd5)) - 8'd1;
      if (req_payload.has_char) begin
         if (info.is_pad) begin
            seen_in = 1'b1;
            if (padc_ff < PAD_MAX) begin
               padc_in = padc_ff + 4'd1;
            end
         end else if (seen_ff) begin
            pad_err_in = 1'b1;
         end else begin
            if (!info.is_symbol) begin
               char_err_in = 1'b1;
            end
            dc_in  = dc_ff + 3'd1;
            cnt_in = cnt_ff + 3'd5;
            buf_in = combined[BUF_W-1:0] & mask[BUF_W-1:0];
            if (cnt_ff >= 3'd3) begin
               byte_ok  = 1'b1;
               byte_val = shifted[7:0];
            end
         end
      end

      pad_sum           = {2'b00, dc_in} + {1'b0, padc_in};
      result.data_byte  = byte_val;
      result.byte_valid = byte_ok;
      result.done_res   = req_payload.end_of_string;
      result.status     = STATUS_OK;
      if (req_payload.end_of_string) begin
         if (pad_err_in || (seen_in && (dc_in == 3'd0 || pad_sum != 5'd8))) begin
            result.status = STATUS_BAD_PAD;
         end else if (dc_in == 3'd1 || dc_in == 3'd3 || dc_in == 3'd6) begin
            result.status = STATUS_BAD_LEN;
         end else if (char_err_in) begin
            result.status = STATUS_BAD_CHAR;
         end else if (buf_in != '0) begin
            result.status = STATUS_BAD_TAIL;
         end
      end
      produce = accept && (byte_ok || req_payload.end_of_string);
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (produce) begin
         if (!out_valid_ff || out_take) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_payload.end_of_string)) begin
         buf_ff      <= '0;
         cnt_ff      <= '0;
         dc_ff       <= '0;
         padc_ff     <= '0;
         seen_ff     <= 1'b0;
         pad_err_ff  <= 1'b0;
         char_err_ff <= 1'b0;
      end else if (accept) begin
         buf_ff      <= buf_in;
         cnt_ff      <= cnt_in;
         dc_ff       <= dc_in;
         padc_ff     <= padc_in;
         seen_ff     <= seen_in;
         pad_err_ff  <= pad_err_in;
         char_err_ff <= char_err_in;
      end
   end

   assign req_stall   = skid_valid_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

### hw/rtl/b32d_symbol_map.sv
module b32d_symbol_map
   import b32d_pkg::*;
(
   input  logic [7:0]   char_code,
   output sym_info_type info
);

   logic [7:0] upper_off;
   logic [7:0] lower_off;
   logic [7:0] digit_off;

   assign upper_off = char_code - UPPER_FIRST;
   assign lower_off = char_code - LOWER_FIRST;
   assign digit_off = char_code - DIGIT_FIRST + DIGIT_OFFSET;

   always_comb begin
      info.is_pad    = (char_code == PAD_CHAR);
      info.is_symbol = 1'b1;
      info.symbol    = 5'd0;
      if (char_code >= UPPER_FIRST && char_code <= UPPER_LAST) begin
         info.symbol = upper_off[4:0];
      end else if (char_code >= LOWER_FIRST && char_code <= LOWER_LAST) begin
         info.symbol = lower_off[4:0];
      end else if (char_code >= DIGIT_FIRST && char_code <= DIGIT_LAST) begin
         info.symbol = digit_off[4:0];
      end else begin
         info.is_symbol = 1'b0;
      end
   end

endmodule

### hw/rtl/b32d_port_checker.sv
module b32d_port_checker
   import b32d_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input req_payload_type req_payload,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_payload))
      else $error("input item changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result item changed while stalled");

   a_rsp_content: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.byte_valid || rsp_payload.done_res)
      else $error("empty result item");

   a_status_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.done_res |-> rsp_payload.status == STATUS_OK)
      else $error("status on a non-final item");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.byte_valid |-> rsp_payload.data_byte == 8'd0)
      else $error("data byte without byte_valid");

endmodule

bind base32_stream_decoder_unit b32d_port_checker u_port_checker (.*);

### tb/tb.sv
module tb;
   import b32d_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0]      ch;
      logic            has;
      logic            last;
      bit              given;
      rsp_payload_type want;
   } directed_row_type;

   localparam rsp_payload_type NO_RESULT = '0;
   localparam int ITEM_TARGET = 1400;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   rsp_payload_type pending_results[$];
   req_payload_type string_items[$];
   int              errors = 0;
   int              burst_left = 0;

   // decoder state as predicted
   logic [11:0] acc_bits;
   logic [2:0]  acc_count;
   logic [2:0]  sym_count_mod8;
   logic [3:0]  pad_run;
   logic        pad_seen;
   logic        pad_fault;
   logic        char_fault;

   directed_row_type directed[20] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, STATUS_OK}},
      '{8'hA5, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h4D, 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{8'h59, 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{PAD_CHAR, 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{PAD_CHAR, 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{PAD_CHAR, 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{PAD_CHAR, 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{PAD_CHAR, 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{PAD_CHAR, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, STATUS_OK}},
      '{8'h41, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, STATUS_BAD_LEN}},
      '{8'h37, 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{8'h37, 1'b1, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, STATUS_BAD_TAIL}},
      '{8'hFF, 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, STATUS_BAD_CHAR}},
      '{PAD_CHAR, 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{8'h61, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, STATUS_BAD_PAD}},
      '{8'h7A, 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{8'h32, 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{8'h5A, 1'b0, 1'b1, 1'b0, NO_RESULT}
   };

   base32_stream_decoder_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
      errors++;
   endtask

   function automatic void clear_decoder();
      acc_bits = '0;
      acc_count = '0;
      sym_count_mod8 = '0;
      pad_run = '0;
      pad_seen = 1'b0;
      pad_fault = 1'b0;
      char_fault = 1'b0;
   endfunction

   function automatic status_type string_status();
      int rem;
      rem = sym_count_mod8;
      if (pad_fault || (pad_seen && (rem == 0 || rem + pad_run != 8)))
         return STATUS_BAD_PAD;
      if (!(rem == 0 || rem == 2 || rem == 4 || rem == 5 || rem == 7))
         return STATUS_BAD_LEN;
      if (char_fault)
         return STATUS_BAD_CHAR;
      if ((acc_bits & ((12'd1 << acc_count) - 12'd1)) != 12'd0)
         return STATUS_BAD_TAIL;
      return STATUS_OK;
   endfunction

   function automatic bit decode_step(input req_payload_type it,
                                      output rsp_payload_type r);
      logic [7:0] c;
      logic [4:0] sym;
      logic [7:0] byte_out;
      bit         got_byte;
      int         n;
      c = it.char_code;
      sym = '0;
      byte_out = '0;
      got_byte = 1'b0;
      r = '0;
      if (it.has_char) begin
         if (c == PAD_CHAR) begin
            pad_seen = 1'b1;
            if (pad_run < PAD_MAX)
               pad_run++;
         end else if (pad_seen) begin
            pad_fault = 1'b1;
         end else begin
            if (c >= UPPER_FIRST && c <= UPPER_LAST)
               sym = 5'(c - UPPER_FIRST);
            else if (c >= LOWER_FIRST && c <= LOWER_LAST)
               sym = 5'(c - LOWER_FIRST);
            else if (c >= DIGIT_FIRST && c <= DIGIT_LAST)
               sym = 5'(c - DIGIT_FIRST + DIGIT_OFFSET);
            else
               char_fault = 1'b1;
            sym_count_mod8 = sym_count_mod8 + 3'd1;
            acc_bits = {acc_bits[6:0], sym};
            n = acc_count + 5;
            if (n >= 8) begin
               n -= 8;
               byte_out = 8'(acc_bits >> n);
               got_byte = 1'b1;
            end
            acc_count = 3'(n);
            acc_bits = acc_bits & ((12'd1 << n) - 12'd1);
         end
      end
      if (it.end_of_string) begin
         r = '{byte_out, got_byte, 1'b1, string_status()};
         clear_decoder();
         return 1'b1;
      end
      if (got_byte) begin
         r = '{byte_out, 1'b1, 1'b0, STATUS_OK};
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [7:0] symbol_char(input logic [4:0] v);
      if (v >= 5'd26)
         return DIGIT_FIRST + 8'(v) - DIGIT_OFFSET;
      return ($urandom_range(0, 1) ? UPPER_FIRST : LOWER_FIRST) + 8'(v);
   endfunction

   // encode random bytes, then damage some of the strings
   task automatic build_string();
      logic [7:0] chars[$];
      int         nbytes;
      int         acc;
      int         nbits;
      int         k;
      int         idx;
      req_payload_type it;
      chars = {};
      string_items = {};
      nbytes = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
      acc = 0;
      nbits = 0;
      for (k = 0; k < nbytes; k++) begin
         acc = ((acc << 8) | $urandom_range(0, 255)) & 'hFFF;
         nbits += 8;
         while (nbits >= 5) begin
            nbits -= 5;
            chars.insert(chars.size(), symbol_char(5'(acc >> nbits)));
         end
      end
      if (nbits > 0)
         chars.insert(chars.size(), symbol_char(5'(acc << (5 - nbits))));
      if ($urandom_range(0, 1))
         while (chars.size() % 8 != 0)
            chars.insert(chars.size(), PAD_CHAR);
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 4))
            0: if (chars.size() > 0)
               chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
            1: chars.insert($urandom_range(0, chars.size()), PAD_CHAR);
            2: if (chars.size() > 0)
               chars.delete($urandom_range(0, chars.size() - 1));
            3: repeat ($urandom_range(1, 11)) chars.insert(chars.size(), PAD_CHAR);
            default: if (chars.size() > 0) begin
               idx = chars.size() - 1;
               while (idx > 0 && chars[idx] == PAD_CHAR)
                  idx--;
               chars[idx] = symbol_char(5'($urandom_range(0, 31)));
            end
         endcase
      end
      foreach (chars[i]) begin
         if ($urandom_range(0, 30) == 0)
            string_items.insert(string_items.size(),
                                '{8'($urandom_range(0, 255)), 1'b0, 1'b0});
         string_items.insert(string_items.size(), '{chars[i], 1'b1, 1'b0});
      end
      if (string_items.size() == 0 || $urandom_range(0, 4) == 0) begin
         string_items.insert(string_items.size(),
                             '{8'($urandom_range(0, 255)), 1'b0, 1'b1});
      end else begin
         it = string_items[$];
         it.end_of_string = 1'b1;
         string_items[$] = it;
      end
   endtask

   task automatic send_item(input req_payload_type it, input bit given,
                            input rsp_payload_type want);
      rsp_payload_type predicted;
      bit              has_result;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_payload <= it;
      do
         @(posedge clock);
      while (req_stall);
      has_result = decode_step(it, predicted);
      if (given)
         pending_results.insert(pending_results.size(), want);
      else if (has_result)
         pending_results.insert(pending_results.size(), predicted);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
   endtask

   initial begin : stall_pattern
      int mode;
      int span;
      int k;
      wait (!reset);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 60);
         for (k = 0; k < span; k++) begin
            @(negedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 9) < 7);
               default: rsp_stall <= (k % 5 < 2);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with none expected", rsp_payload.data_byte, 8'h00);
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.data_byte !== want.data_byte)
               report_mismatch("data_byte", rsp_payload.data_byte, want.data_byte);
            if (rsp_payload.byte_valid !== want.byte_valid)
               report_mismatch("byte_valid", 8'(rsp_payload.byte_valid), 8'(want.byte_valid));
            if (rsp_payload.done_res !== want.done_res)
               report_mismatch("done_res", 8'(rsp_payload.done_res), 8'(want.done_res));
            if (rsp_payload.status !== want.status)
               report_mismatch("status", 8'(rsp_payload.status), 8'(want.status));
         end
      end
   end

   initial begin : stimulus
      int fed;
      clear_decoder();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed[i])
         send_item('{directed[i].ch, directed[i].has, directed[i].last},
                   directed[i].given, directed[i].want);
      drain_results();
      fed = 0;
      while (fed < ITEM_TARGET) begin
         build_string();
         foreach (string_items[i]) begin
            send_item(string_items[i], 1'b0, NO_RESULT);
            if (string_items[i].has_char || string_items[i].end_of_string)
               fed++;
         end
         if ($urandom_range(0, 40) == 0)
            drain_results();
      end
      drain_results();
      repeat (10) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never arrived", 8'(pending_results.size()), 8'h00);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/b32d_pkg.sv
hw/rtl/b32d_symbol_map.sv
hw/rtl/base32_stream_decoder_unit.sv
hw/rtl/b32d_port_checker.sv
tb/tb.sv
